[design/cgr_pkg.sv]
// ----------------------------------------------------------------------------
// cgr_pkg: shared types and constants for the constrained restriction block
// Widths, line buffer geometry, sequencer states and helper functions.
// ----------------------------------------------------------------------------
package cgr_pkg;

  localparam int MAX_FINE_SIDE = 1025;
  localparam int SIDE_RESET    = 513;
  localparam int CNT_W         = $clog2(MAX_FINE_SIDE + 1);
  localparam int COARSE_W      = 10;
  localparam int ALPHA_W       = 17;
  localparam int VAL_W         = 32;
  localparam int ENTRY_W       = ALPHA_W + 2 * VAL_W;
  localparam int MEM_DEPTH     = 3 * MAX_FINE_SIDE;
  localparam int ADDR_W        = $clog2(MEM_DEPTH);
  localparam int PROD_W        = ALPHA_W + 1 + VAL_W;
  localparam int ACC_W         = 54;
  localparam int DEN_W         = 21;
  localparam int NUM_W         = ACC_W + 2;
  localparam int DIVR_W        = DEN_W + 1;
  localparam int STEP_W        = $clog2(NUM_W + 1);
  localparam int IN_DATA_W     = ((ENTRY_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W  = 2 * COARSE_W + 2 * VAL_W;
  localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_CALC,
    ST_DIV,
    ST_DONE
  } cgr_state_e;

  // one neighbour read issued to the line buffers
  typedef struct packed {
    logic       valid;
    logic       clear;
    logic [1:0] shift;   // log2 of the stencil weight in quarters
  } cgr_tap_t;

  // (m - d) mod 3, both below 3
  function automatic logic [1:0] mod3_sub(input logic [1:0] m, input logic [1:0] d);
    logic [2:0] t;
    t = {1'b0, m} + 3'd3 - {1'b0, d};
    if (t >= 3'd3) t = t - 3'd3;
    return t[1:0];
  endfunction

  function automatic logic [1:0] mod3_inc(input logic [1:0] m);
    return (m == 2'd2) ? 2'd0 : m + 2'd1;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [1:0] m,
                                                  input logic [CNT_W-1:0] col);
    logic [ADDR_W-1:0] base;
    unique case (m)
      2'd1:    base = ADDR_W'(MAX_FINE_SIDE);
      2'd2:    base = ADDR_W'(2 * MAX_FINE_SIDE);
      default: base = '0;
    endcase
    return base + ADDR_W'(col);
  endfunction

endpackage

[design/constrained_grid_restriction.sv]
// ----------------------------------------------------------------------------
// constrained_grid_restriction: clipped full-weighting restriction to a coarse grid
// Sequence: a fine beat that closes no coarse cell is only stored. One that closes
//   a coarse cell starts a walk of n = 4, 6 or 9 line-buffer reads, one per
//   cycle on the single read port, then drains the accumulators; a fixed cell then
//   runs the 56-step divider, and the result waits for room in the output register.
// Throughput: one beat per cycle between coarse cells; the divider sets the
//   sustained rate on fixed cells. Reset: counters zero, side 513, no clearing pass.
// ----------------------------------------------------------------------------
module constrained_grid_restriction
  import cgr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // fine cell beats
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [16:0] blend_weight, [48:17] height_value, [80:49] curvature_value
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // [0] first_cell
  input  logic                  s_axis_tuser_i,
  // coarse cell beats
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [9:0] coarse_row, [19:10] coarse_col, [51:20] coarse_height,
  // [83:52] coarse_curvature
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // [0] height_fixed
  output logic                  m_axis_tuser_o,
  output logic                  m_axis_tlast_o,
  // fine_side register
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CNT_W-1:0]      cfg_data_i
);

  cgr_state_e state_q, state_d;

  logic [CNT_W-1:0] side_q;
  logic [CNT_W-1:0] row_q, col_q;
  logic [1:0]       rmod_q;

  // effective side: clamped, odd, at least 3
  logic [CNT_W-1:0] side_eff, last;
  always_comb begin
    side_eff = (side_q > CNT_W'(MAX_FINE_SIDE)) ? CNT_W'(MAX_FINE_SIDE) : side_q;
    if (!side_eff[0] && side_eff != '0) side_eff = side_eff - 1'b1;
    if (side_eff < CNT_W'(3)) side_eff = CNT_W'(3);
    last = side_eff - 1'b1;
  end

  // position of the arriving beat
  logic [CNT_W-1:0]   r, c;
  logic [1:0]         rm;
  logic [ALPHA_W-1:0] a_in, a_sat;
  logic               in_fire, emit;
  always_comb begin
    r  = s_axis_tuser_i ? '0 : row_q;
    c  = s_axis_tuser_i ? '0 : col_q;
    rm = s_axis_tuser_i ? 2'd0 : rmod_q;
    if (r >= side_eff) begin
      r  = '0;
      rm = 2'd0;
    end
    if (c >= side_eff) c = '0;
    a_in  = s_axis_tdata_i[ALPHA_W-1:0];
    a_sat = (a_in > ALPHA_ONE) ? ALPHA_ONE : a_in;
    emit  = (r[0] || r == last) && (c[0] || c == last);
  end
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  // neighbourhood bounds of the coarse cell closed by this beat
  logic [CNT_W-1:0] rc, cc, rlo, rhi, clo, chi;
  logic [CNT_W-1:0] rdist;
  always_comb begin
    rc    = {r[CNT_W-1:1], 1'b0};
    cc    = {c[CNT_W-1:1], 1'b0};
    rlo   = (r[CNT_W-1:1] == '0) ? '0 : rc - 1'b1;
    clo   = (c[CNT_W-1:1] == '0) ? '0 : cc - 1'b1;
    rhi   = (rc + 1'b1 > last) ? last : rc + 1'b1;
    chi   = (cc + 1'b1 > last) ? last : cc + 1'b1;
    rdist = r - rlo;
  end

  // scan registers
  logic [CNT_W-1:0]    scan_row_q, scan_col_q, rc_q, cc_q, rhi_q, clo_q, chi_q;
  logic [1:0]          scan_mod_q;
  logic [COARSE_W-1:0] ci_q, cj_q;
  logic                last_q;
  logic                scan_end;
  assign scan_end = (scan_col_q == chi_q) && (scan_row_q == rhi_q);

  // line buffers
  logic [ENTRY_W-1:0] rdata;
  cgr_tap_t           tap;

  cgr_line_mem u_mem (
    .clk_i  (clk_i),
    .we_i   (in_fire),
    .waddr_i(slot_addr(rm, c)),
    .wdata_i({s_axis_tdata_i[ALPHA_W+VAL_W +: VAL_W],
              s_axis_tdata_i[ALPHA_W +: VAL_W], a_sat}),
    .re_i   (tap.valid),
    .raddr_i(slot_addr(scan_mod_q, scan_col_q)),
    .rdata_o(rdata)
  );

  logic                    mac_busy, fixed;
  logic signed [ACC_W-1:0] num, lap;
  logic [DEN_W-1:0]        den;

  cgr_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tap_i  (tap),
    .rdata_i(rdata),
    .busy_o (mac_busy),
    .fixed_o(fixed),
    .num_o  (num),
    .den_o  (den),
    .lap_o  (lap)
  );

  // rounded altitude: floor((2 num + den) / (2 den))
  logic                    div_start, div_busy, div_done;
  logic signed [NUM_W:0]   quo;
  logic signed [NUM_W-1:0] n2;
  assign n2 = (NUM_W'(num) <<< 1) + $signed(NUM_W'({1'b0, den}));

  cgr_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(n2),
    .divisor_i ({den, 1'b0}),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quotient_o(quo)
  );

  localparam logic signed [VAL_W-1:0] S32_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] S32_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // laplacian: sum / 2^18 rounded half up, saturated
  localparam int LSH_W = ACC_W + 1 - 18;
  logic signed [ACC_W:0]   lap_r;
  logic signed [LSH_W-1:0] lap_sh;
  logic signed [VAL_W-1:0] lap_sat, hgt_sat;
  always_comb begin
    lap_r  = (ACC_W+1)'(lap) + (ACC_W+1)'(1 << 17);
    lap_sh = LSH_W'(lap_r >>> 18);
    if (lap_sh > LSH_W'(S32_MAX))      lap_sat = S32_MAX;
    else if (lap_sh < LSH_W'(S32_MIN)) lap_sat = S32_MIN;
    else                               lap_sat = VAL_W'(lap_sh);
    if (quo > (NUM_W+1)'(S32_MAX))      hgt_sat = S32_MAX;
    else if (quo < (NUM_W+1)'(S32_MIN)) hgt_sat = S32_MIN;
    else                                hgt_sat = VAL_W'(quo);
  end

  // output register
  logic                    out_valid_q, out_load;
  logic signed [VAL_W-1:0] res_h_q, res_k_q;
  logic [OUT_DATA_W-1:0]   out_data_q;
  logic                    out_fixed_q, out_last_q;

  // sequencer
  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    tap             = '0;
    div_start       = 1'b0;
    out_load        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (in_fire && emit) begin
          tap.clear = 1'b1;
          state_d   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        tap.valid = 1'b1;
        tap.shift = 2'((scan_row_q == rc_q) ? 1 : 0) + 2'((scan_col_q == cc_q) ? 1 : 0);
        if (scan_end) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!mac_busy) state_d = ST_CALC;
      end
      ST_CALC: begin
        if (fixed) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      side_q  <= CNT_W'(SIDE_RESET);
      row_q   <= '0;
      col_q   <= '0;
      rmod_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        side_q <= cfg_data_i;
        row_q  <= '0;
        col_q  <= '0;
        rmod_q <= 2'd0;
      end else if (in_fire) begin
        if (c + 1'b1 >= side_eff) begin
          col_q <= '0;
          if (r + 1'b1 >= side_eff) begin
            row_q  <= '0;
            rmod_q <= 2'd0;
          end else begin
            row_q  <= r + 1'b1;
            rmod_q <= mod3_inc(rm);
          end
        end else begin
          col_q  <= c + 1'b1;
          row_q  <= r;
          rmod_q <= rm;
        end
      end
    end
  end

  // walk the neighbourhood row by row
  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      scan_row_q <= rlo;
      scan_mod_q <= mod3_sub(rm, rdist[1:0]);
      scan_col_q <= clo;
      rc_q       <= rc;
      cc_q       <= cc;
      rhi_q      <= rhi;
      clo_q      <= clo;
      chi_q      <= chi;
      ci_q       <= COARSE_W'(r >> 1);
      cj_q       <= COARSE_W'(c >> 1);
      last_q     <= (r == last) && (c == last);
    end else if (state_q == ST_SCAN) begin
      if (scan_col_q == chi_q) begin
        scan_col_q <= clo_q;
        scan_row_q <= scan_row_q + 1'b1;
        scan_mod_q <= mod3_inc(scan_mod_q);
      end else begin
        scan_col_q <= scan_col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CALC) begin
      res_h_q <= '0;
      res_k_q <= fixed ? '0 : lap_sat;
    end else if (div_done) begin
      res_h_q <= hgt_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q  <= OUT_DATA_W'({res_k_q, res_h_q, cj_q, ci_q});
      out_fixed_q <= fixed;
      out_last_q  <= last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_fixed_q;
  assign m_axis_tlast_o  = out_last_q;
  assign cfg_ready_o     = 1'b1;

  // divider only runs for a fixed cell
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_start |-> fixed)
    else $error("divider started for a free cell");

  // the accumulators are settled whenever the block takes a new beat
  assert property (@(posedge clk_i) disable iff (!rst_ni) s_axis_tready_o |-> !mac_busy)
    else $error("stencil pipeline busy while accepting");

  // a closing beat starts the neighbourhood walk next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (in_fire && emit) |=> (state_q == ST_SCAN))
    else $error("coarse cell not started");

  // divider is idle outside the division state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   div_busy |-> (state_q == ST_DIV))
    else $error("divider busy outside division");

endmodule

[design/cgr_line_mem.sv]
// ----------------------------------------------------------------------------
// cgr_line_mem: three fine rows of alpha, altitude and laplacian
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cgr_line_mem
  import cgr_pkg::*;
(
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [ADDR_W-1:0]  waddr_i,
  input  logic [ENTRY_W-1:0] wdata_i,
  input  logic               re_i,
  input  logic [ADDR_W-1:0]  raddr_i,
  output logic [ENTRY_W-1:0] rdata_o
);

  logic [ENTRY_W-1:0] mem [MEM_DEPTH];
  logic [ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/cgr_mac.sv]
// ----------------------------------------------------------------------------
// cgr_mac: stencil accumulators
// Multiplies each neighbour read, then accumulates altitude, weight and
// laplacian sums scaled by the stencil weight.
// ----------------------------------------------------------------------------
module cgr_mac
  import cgr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cgr_tap_t                tap_i,
  input  logic [ENTRY_W-1:0]      rdata_i,
  output logic                    busy_o,
  output logic                    fixed_o,
  output logic signed [ACC_W-1:0] num_o,
  output logic [DEN_W-1:0]        den_o,
  output logic signed [ACC_W-1:0] lap_o
);

  logic                     rd_valid_q, prod_valid_q;
  logic [1:0]               rd_shift_q, prod_shift_q;
  logic [ALPHA_W-1:0]       w;
  logic [ALPHA_W-1:0]       om;
  logic signed [VAL_W-1:0]  h, k;
  logic signed [PROD_W-1:0] p_num_q, p_lap_q;
  logic [ALPHA_W-1:0]       om_q;
  logic                     low_q;
  logic                     fixed_q;
  logic signed [ACC_W-1:0]  num_q, lap_q;
  logic [DEN_W-1:0]         den_q;

  assign w  = rdata_i[ALPHA_W-1:0];
  assign h  = rdata_i[ALPHA_W +: VAL_W];
  assign k  = rdata_i[ALPHA_W+VAL_W +: VAL_W];
  assign om = ALPHA_ONE - w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q   <= 1'b0;
      prod_valid_q <= 1'b0;
    end else begin
      rd_valid_q   <= tap_i.valid;
      prod_valid_q <= rd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_shift_q   <= tap_i.shift;
    prod_shift_q <= rd_shift_q;
    p_num_q      <= $signed({1'b0, om}) * h;
    p_lap_q      <= $signed({1'b0, w}) * k;
    om_q         <= om;
    low_q        <= (w < ALPHA_ONE);
  end

  always_ff @(posedge clk_i) begin
    if (tap_i.clear) begin
      num_q   <= '0;
      lap_q   <= '0;
      den_q   <= '0;
      fixed_q <= 1'b0;
    end else if (prod_valid_q) begin
      num_q   <= num_q + (ACC_W'(p_num_q) <<< prod_shift_q);
      lap_q   <= lap_q + (ACC_W'(p_lap_q) <<< prod_shift_q);
      den_q   <= den_q + (DEN_W'(om_q) << prod_shift_q);
      fixed_q <= fixed_q | low_q;
    end
  end

  assign busy_o  = rd_valid_q | prod_valid_q;
  assign fixed_o = fixed_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign lap_o   = lap_q;

endmodule

[design/cgr_divider.sv]
// ----------------------------------------------------------------------------
// cgr_divider: iterative signed floor division
// Restoring division on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cgr_divider
  import cgr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] dividend_i,
  input  logic [DIVR_W-1:0]       divisor_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic signed [NUM_W:0]   quotient_o
);

  logic              busy_q, done_q, neg_q;
  logic [STEP_W-1:0] cnt_q;
  logic [NUM_W-1:0]  mag_q;
  logic [DIVR_W-1:0] rem_q, div_q;
  logic [DIVR_W:0]   trial, diff;
  logic              ge;
  logic [NUM_W:0]    q_mag;

  assign trial = {rem_q, mag_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= STEP_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[NUM_W-1];
      mag_q <= dividend_i[NUM_W-1] ? NUM_W'(-dividend_i) : dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      mag_q <= {mag_q[NUM_W-2:0], ge};
      rem_q <= ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
    end
  end

  // floor: a negative quotient with a remainder steps one further down
  assign q_mag      = {1'b0, mag_q} + (NUM_W+1)'(neg_q && (rem_q != '0));
  assign quotient_o = neg_q ? -$signed(q_mag) : $signed(q_mag);
  assign busy_o     = busy_q;
  assign done_o     = done_q;

endmodule
